>>> rtl/fcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared constants, command and status types for the Feistel cycle-walk
// index permutation block.
// ----------------------------------------------------------------------------
package fcw_pkg;

  // Mixing function constants. The two key words are folded with the pi words.
  localparam logic [63:0] MIX_MUL = 64'h5851f42d4c957f2d;
  localparam logic [63:0] MIX_BUF = 64'ha4093822299f31d0 ^ 64'h243f6a8885a308d3;
  localparam logic [63:0] MIX_PAD = 64'h082efa98ec4e6c89 ^ 64'h13198a2e03707344;
  localparam logic [5:0]  ROT_D1  = 6'd8;
  localparam logic [5:0]  ROT_BUF = 6'd24;

  // Partial product select for the shared 32x32 multiplier.
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_LL = 2'd0;
  localparam mul_sel_t MUL_LH = 2'd1;
  localparam mul_sel_t MUL_HL = 2'd2;

  // Accumulator operation applied to the registered product.
  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_NONE = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_ADD  = 2'd2;

  // Operand preparation after a 64-bit product completes.
  typedef logic [1:0] prep_t;
  localparam prep_t PREP_NONE = 2'd0;
  localparam prep_t PREP_D1   = 2'd1;
  localparam prep_t PREP_PAD  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     rstart;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    prep_t    prep;
    logic     fin;
    logic     walk_inc;
    logic     res_take;
    logic     out_load;
  } fcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic trivial;
    logic below_n;
    logic walk_last;
  } fcw_sts_t;

endpackage

>>> rtl/fcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_ctrl
// Controller state machine: sequences setup, the multiply steps of each
// Feistel round, the cycle-walk check and the result handoff.
// ----------------------------------------------------------------------------
module fcw_ctrl
  import fcw_pkg::*;
#(
  parameter int ROUNDS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fcw_sts_t sts,
  output fcw_cmd_t cmd
);

  localparam int RCW = $clog2(ROUNDS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_RSTART = 4'd2;
  localparam logic [3:0] S_M0     = 4'd3;
  localparam logic [3:0] S_M1     = 4'd4;
  localparam logic [3:0] S_M2     = 4'd5;
  localparam logic [3:0] S_M3     = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // Which of the three products of the mixing function is in progress.
  localparam logic [1:0] MIX_D1  = 2'd0;
  localparam logic [1:0] MIX_PD  = 2'd1;
  localparam logic [1:0] MIX_BF  = 2'd2;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     mul_idx_r, mul_idx_nxt;
  logic [RCW-1:0] round_cnt_r, round_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    mul_idx_nxt   = mul_idx_r;
    round_cnt_nxt = round_cnt_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_LL;
    cmd.acc_op    = ACC_NONE;
    cmd.prep      = PREP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup     = 1'b1;
        round_cnt_nxt = '0;
        if (!sts.in_range || sts.trivial) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RSTART;
        end
      end
      S_RSTART: begin
        cmd.rstart  = 1'b1;
        mul_idx_nxt = MIX_D1;
        state_nxt   = S_M0;
      end
      S_M0: begin
        cmd.mul_sel = MUL_LL;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MUL_LH;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MUL_HL;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.acc_op = ACC_ADD;
        case (mul_idx_r)
          MIX_D1:  cmd.prep = PREP_D1;
          MIX_PD:  cmd.prep = PREP_PAD;
          default: cmd.prep = PREP_NONE;
        endcase
        if (mul_idx_r == MIX_BF) begin
          state_nxt = S_FIN;
        end else begin
          mul_idx_nxt = mul_idx_r + 2'd1;
          state_nxt   = S_M0;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (round_cnt_r == RCW'(ROUNDS - 1)) begin
          state_nxt = S_CHECK;
        end else begin
          round_cnt_nxt = round_cnt_r + RCW'(1);
          state_nxt     = S_RSTART;
        end
      end
      S_CHECK: begin
        if (sts.below_n || sts.walk_last) begin
          cmd.res_take = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.walk_inc  = 1'b1;
          round_cnt_nxt = '0;
          state_nxt     = S_RSTART;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output slot fills on a load and drains on an accepted transaction.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_idx_r   <= MIX_D1;
      round_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_idx_r   <= mul_idx_nxt;
      round_cnt_r <= round_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/fcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_datapath
// Operand registers, the shared 32x32 multiplier with its accumulator, the
// Feistel round update, the cycle-walk counter and the result register.
// ----------------------------------------------------------------------------
module fcw_datapath
  import fcw_pkg::*;
#(
  parameter int INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic [31:0] in_index_in,
  input  logic [31:0] in_set_size,
  output logic [31:0] out_index_out,
  output logic        out_valid_res,
  input  fcw_cmd_t    cmd,
  output fcw_sts_t    sts
);

  localparam int W  = INDEX_WIDTH;
  localparam int BW = $clog2(W + 1);

  logic [W-1:0]  k_r, n_r, v_r, res_r;
  logic [W-1:0]  walk_cnt_r;
  logic [BW-1:0] bits_r, hi_r, lo_r;
  logic [63:0]   opa_r, acc_r, pad_r, buf_r, prod_r;
  logic [31:0]   index_out_r;
  logic          valid_res_r;

  logic [W-1:0]  m, hi_mask, lo_mask, l_half, r_half, t_half, v_fin;
  logic [BW-1:0] bits, hi_bits, lo_bits;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod_nxt, acc_nxt, f_mix, d1_op, buf_op;

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] d;
    begin
      d = {v, v} << s;
      return d[127:64];
    end
  endfunction

  // Domain width: the bit count of n - 1.
  always_comb begin
    m    = n_r - W'(1);
    bits = '0;
    for (int i = 0; i < W; i++) begin
      if (m[i]) begin
        bits = BW'(i + 1);
      end
    end
  end

  assign hi_bits = bits >> 1;
  assign lo_bits = bits - hi_bits;

  // Half masks and halves of the working value.
  assign hi_mask = W'(((W + 1)'(1) << hi_r) - (W + 1)'(1));
  assign lo_mask = W'(((W + 1)'(1) << lo_r) - (W + 1)'(1));
  assign l_half  = (v_r >> lo_r) & hi_mask;
  assign r_half  = v_r & lo_mask;

  // Partial product selection; only the low 64 bits of the full product are kept.
  always_comb begin
    case (cmd.mul_sel)
      MUL_LH: begin
        mul_a = opa_r[31:0];
        mul_b = MIX_MUL[63:32];
      end
      MUL_HL: begin
        mul_a = opa_r[63:32];
        mul_b = MIX_MUL[31:0];
      end
      default: begin
        mul_a = opa_r[31:0];
        mul_b = MIX_MUL[31:0];
      end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  // Accumulator: low product loads, cross products add into the upper word.
  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
      default:  acc_nxt = acc_r;
    endcase
  end

  // Operands for the second and third products of the mixing function.
  assign d1_op  = rotl(MIX_PAD ^ acc_nxt, ROT_D1);
  assign buf_op = rotl(MIX_BUF ^ acc_nxt, ROT_BUF);

  // Round update: finish the mix, then swap and combine the halves.
  assign f_mix  = rotl(acc_r ^ pad_r, buf_r[5:0]);
  assign t_half = (l_half ^ f_mix[W-1:0]) & hi_mask;
  assign v_fin  = (r_half << hi_r) | t_half;

  // Status for the controller.
  assign sts.in_range  = k_r < n_r;
  assign sts.trivial   = n_r < W'(2);
  assign sts.below_n   = v_r < n_r;
  assign sts.walk_last = ({1'b0, walk_cnt_r} + (W + 1)'(1)) == ((W + 1)'(1) << bits_r);

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load_in) begin
      k_r <= in_index_in[W-1:0];
      n_r <= in_set_size[W-1:0];
    end
    if (cmd.setup) begin
      bits_r     <= bits;
      hi_r       <= hi_bits;
      lo_r       <= lo_bits;
      v_r        <= k_r;
      walk_cnt_r <= '0;
      res_r      <= sts.in_range ? k_r : '0;
    end
    if (cmd.rstart) begin
      opa_r <= 64'(r_half) ^ MIX_BUF;
    end
    case (cmd.prep)
      PREP_D1: begin
        opa_r <= d1_op;
      end
      PREP_PAD: begin
        pad_r <= acc_nxt;
        buf_r <= buf_op;
        opa_r <= buf_op;
      end
      default: begin
      end
    endcase
    if (cmd.fin) begin
      v_r <= v_fin;
    end
    if (cmd.walk_inc) begin
      walk_cnt_r <= walk_cnt_r + W'(1);
    end
    if (cmd.res_take) begin
      res_r <= sts.below_n ? v_r : k_r;
    end
    if (cmd.out_load) begin
      index_out_r <= 32'(res_r);
      valid_res_r <= sts.in_range;
    end
  end

  assign out_index_out = index_out_r;
  assign out_valid_res = valid_res_r;

endmodule

>>> rtl/feistel_cycle_walk_index_permute_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_cycle_walk_index_permute_top
// Keyed pseudorandom permutation of an index within 0..n-1 by unbalanced
// Feistel rounds over a power-of-two domain with cycle walking.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Each cycle-walk pass runs ROUNDS Feistel
// rounds and then a check; passes repeat until the value falls below n or the
// walk counter reaches its limit. An out-of-range index or a one-element set
// skips the rounds. Each round steps through the mixing function, which has
// three dependent 64-bit products, each built from three partial products on a
// single shared 32x32 multiplier. The finished result sits in an output
// register, so the next transaction is accepted while it waits to be taken.
module feistel_cycle_walk_index_permute_top
  import fcw_pkg::*;
#(
  parameter int INDEX_WIDTH = 32,
  parameter int ROUNDS      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_index_in,
  input  logic [31:0] in_set_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_index_out,
  output logic        out_valid_res
);

  fcw_cmd_t cmd;
  fcw_sts_t sts;

  // Controller.
  fcw_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  fcw_datapath #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .in_index_in  (in_index_in),
    .in_set_size  (in_set_size),
    .out_index_out(out_index_out),
    .out_valid_res(out_valid_res),
    .cmd          (cmd),
    .sts          (sts)
  );

  // A new result appears only as the controller returns to idle.
  a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while the controller was busy");

  // An accepted transaction makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block still ready right after accepting a transaction");

  // A result for an out-of-range index carries a zero index.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_index_out == 32'd0))
    else $error("invalid result with nonzero index");

endmodule

>>> test/feistel_cycle_walk_index_permute_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_cycle_walk_index_permute_top_test
// Drives index and set-size pairs into the permutation block and compares
// every result against a local Feistel cycle-walk predictor. The test covers
// out-of-range indexes, one- and two-element sets, extreme set sizes, a long
// output stall, and random traffic under three idle patterns.
// ----------------------------------------------------------------------------
module feistel_cycle_walk_index_permute_top_test;
  import fcw_pkg::*;

  localparam int IDX_W      = 32;
  localparam int NUM_ROUNDS = 4;
  localparam int LONG_STALL = 600;
  localparam int DRAIN_WAIT = 300;

  // One expected permutation result, with its inputs kept for messages.
  typedef struct packed {
    logic [31:0] k;
    logic [31:0] n;
    logic [31:0] index;
    logic        ok;
  } perm_res_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [31:0] in_index_in   = '0;
  logic [31:0] in_set_size   = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [31:0] out_index_out;
  logic        out_valid_res;

  perm_res_t expected_perms[$];
  int        err_count    = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        stall_reqs   = 0;
  int        stall_taken  = 0;
  int        stall_left   = 0;

  feistel_cycle_walk_index_permute_top #(
    .INDEX_WIDTH(IDX_W),
    .ROUNDS     (NUM_ROUNDS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_index_in  (in_index_in),
    .in_set_size  (in_set_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index_out(out_index_out),
    .out_valid_res(out_valid_res)
  );

  // Clock generation, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run guard in case the block hangs.
  initial begin
    #16_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] s);
    if (s == 6'd0) return v;
    return (v << s) | (v >> (7'd64 - {1'b0, s}));
  endfunction

  // Keyed multiply/rotate mixing applied to the right half in each round.
  function automatic logic [63:0] round_mix(input logic [63:0] x);
    logic [63:0] bw;
    logic [63:0] pw;
    logic [63:0] d1;
    bw = MIX_BUF;
    pw = MIX_PAD;
    d1 = (x ^ bw) * MIX_MUL;
    pw = rotl64(pw ^ d1, ROT_D1) * MIX_MUL;
    bw = rotl64(bw ^ pw, ROT_BUF);
    return rotl64((bw * MIX_MUL) ^ pw, bw[5:0]);
  endfunction

  // One full set of unbalanced Feistel rounds over a hi_bits + lo_bits domain.
  function automatic logic [63:0] feistel_pass(input logic [63:0] v_in, input int hi_bits,
                                               input int lo_bits);
    logic [63:0] v;
    logic [63:0] hi_mask;
    logic [63:0] lo_mask;
    logic [63:0] l;
    logic [63:0] r;
    logic [63:0] t;
    v       = v_in;
    hi_mask = (64'd1 << hi_bits) - 64'd1;
    lo_mask = (64'd1 << lo_bits) - 64'd1;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      l = (v >> lo_bits) & hi_mask;
      r = v & lo_mask;
      t = (l ^ round_mix(r)) & hi_mask;
      v = (r << hi_bits) | (t & lo_mask);
    end
    return v;
  endfunction

  // Expected output for one index and set size, walking until below n or the walk limit.
  function automatic perm_res_t permute_index(input logic [31:0] k, input logic [31:0] n);
    perm_res_t        res;
    logic [63:0]      v;
    logic [31:0]      m;
    int               bits;
    int               hi_bits;
    longint unsigned  walk_limit;
    longint unsigned  iter;
    logic             done;
    res.k     = k;
    res.n     = n;
    res.index = '0;
    res.ok    = 1'b0;
    if (k >= n) return res;
    res.ok = 1'b1;
    if (n > 32'd1) begin
      bits = 0;
      m    = n - 32'd1;
      while (m != 32'd0) begin
        bits++;
        m = m >> 1;
      end
      hi_bits    = bits / 2;
      walk_limit = 64'd1 << bits;
      v          = {32'd0, k};
      done       = 1'b0;
      for (iter = 0; iter < walk_limit && !done; iter++) begin
        v    = feistel_pass(v, hi_bits, bits - hi_bits);
        done = (v < {32'd0, n});
      end
      res.index = done ? v[31:0] : k;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  // Random ready, with a long hold-off whenever a stall is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_left  <= 0;
      stall_taken <= 0;
    end else if (stall_reqs != stall_taken) begin
      stall_taken <= stall_reqs;
      stall_left  <= LONG_STALL;
      out_ready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    perm_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_perms.size() == 0) begin
        flag_error($sformatf("unexpected result index_out=%h valid_res=%b",
                             out_index_out, out_valid_res));
      end else begin
        exp_r = expected_perms.pop_front();
        if (out_index_out !== exp_r.index)
          flag_error($sformatf("k=%h n=%h index_out expected %h got %h",
                               exp_r.k, exp_r.n, exp_r.index, out_index_out));
        if (out_valid_res !== exp_r.ok)
          flag_error($sformatf("k=%h n=%h valid_res expected %b got %b",
                               exp_r.k, exp_r.n, exp_r.ok, out_valid_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction and record its expected result on acceptance.
  // Valid is only lowered when the sender chooses to idle.
  task automatic send_perm(input logic [31:0] k, input logic [31:0] n);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_index_in <= k;
    in_set_size <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_perms.push_back(permute_index(k, n));
  endtask

  // Random pair: sizes spread over all bit lengths, mostly in-range indexes.
  task automatic pick_item(output logic [31:0] k, output logic [31:0] n);
    int sel;
    sel = $urandom_range(0, 99);
    n   = $urandom >> $urandom_range(0, 31);
    if (sel < 5) n = $urandom_range(0, 2);
    else if (sel < 10) n = $urandom;
    if (sel >= 85 || n == 32'd0) begin
      if ($urandom_range(0, 1) == 0) k = $urandom;
      else k = n + $urandom_range(0, 32'hFFFF_FFFF - n);
    end else begin
      k = $urandom % n;
    end
  endtask

  task automatic wait_results_done();
    while (expected_perms.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Index not below the set size, including an empty set.
  task automatic test_out_of_range();
    send_perm(32'h0000_0000, 32'h0000_0000);
    send_perm(32'hFFFF_FFFF, 32'h0000_0000);
    send_perm(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_perm(32'h0000_0007, 32'h0000_0007);
    send_perm(32'h8000_0000, 32'h0000_0010);
    send_perm(32'h0000_0001, 32'h0000_0001);
  endtask

  // One-element set maps to zero; two-element set is the identity; three- and four-element sets follow.
  task automatic test_tiny_sets();
    send_perm(32'd0, 32'd1);
    send_perm(32'd0, 32'd2);
    send_perm(32'd1, 32'd2);
    send_perm(32'd0, 32'd3);
    send_perm(32'd2, 32'd3);
    send_perm(32'd3, 32'd4);
  endtask

  // Largest sizes, exact powers of two and sizes just over a power of two.
  task automatic test_extreme_sizes();
    send_perm(32'h0000_0000, 32'hFFFF_FFFF);
    send_perm(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_perm(32'h8000_0000, 32'h8000_0001);
    send_perm(32'h5555_5555, 32'hAAAA_AAAA);
    send_perm(32'h0000_FFFF, 32'h0001_0000);
    send_perm(32'h0001_2345, 32'h0001_0001);
    send_perm(32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // Hold the result side off while the sender keeps offering transactions.
  task automatic test_backpressure();
    logic [31:0] k;
    logic [31:0] n;
    src_idle_pct = 0;
    stall_reqs  <= stall_reqs + 1;
    for (int i = 0; i < 10; i++) begin
      pick_item(k, n);
      send_perm(k, n);
    end
  endtask

  task automatic test_random(input int count, input int src_pct, input int snk_pct);
    logic [31:0] k;
    logic [31:0] n;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < count; i++) begin
      pick_item(k, n);
      send_perm(k, n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 19;
    snk_idle_pct = 76;
    test_out_of_range();
    test_tiny_sets();
    test_extreme_sizes();
    test_backpressure();
    test_random(250, 19, 76);
    test_random(250, 76, 19);
    test_random(250, 0, 0);
    in_valid <= 1'b0;

    wait_results_done();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && expected_perms.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
